// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the conditioner RTL.
// Used by files that assert; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same, checked on every edge including reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/jabc_pkg.sv =====
// Package for the joystick axis and button conditioner.
// Payload structs, item kind codes, register indexes and constants; no dependencies.
`timescale 1ns / 1ps

package jabc_pkg;

  // Default number of calibration table entries.
  localparam int unsigned AXIS_COUNT_DEF = 8;

  // Reset value of the axes-in-use register.
  localparam logic [3:0] AXES_IN_USE_RST = 4'd8;

  // Gain scaling: gains carry seven fraction bits.
  localparam int unsigned GAIN_SHIFT = 7;

  // Saturation limits of a conditioned axis value.
  localparam logic signed [15:0] AXIS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] AXIS_MIN = -16'sh8000;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_AXIS   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_CAL    = 2'd2
  } kind_e;

  // Result item kinds.
  typedef enum logic {
    OUT_AXIS   = 1'b0,
    OUT_BUTTON = 1'b1
  } out_kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAL_ENABLE  = 3'd0,
    REG_AXES_IN_USE = 3'd1,
    REG_LATCH_MASK  = 3'd2,
    REG_AUTOFIRE    = 3'd3
  } cfg_reg_e;

  // Input item.
  typedef struct packed {
    kind_e              kind;
    logic [2:0]         axis_index;
    logic signed [15:0] axis_value;
    logic [31:0]        button_word;
    logic               cal_active;
    logic signed [15:0] cal_low_dead;
    logic signed [15:0] cal_high_dead;
    logic signed [15:0] cal_low_gain;
    logic signed [15:0] cal_high_gain;
  } in_t;

  // Result item.
  typedef struct packed {
    out_kind_e          out_kind;
    logic [2:0]         out_axis_index;
    logic signed [15:0] out_axis_value;
    logic [31:0]        out_buttons;
  } out_t;

  // Button conditioning controls.
  typedef struct packed {
    logic        enable;
    logic [31:0] latch_mask;
    logic [31:0] autofire_mask;
  } btn_cfg_t;

endpackage

// ===== rtl/jabc_button_cond.sv =====
// Button latch (toggle) and autofire conditioning with its press/latch/phase state.
// Depends on jabc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jabc_button_cond (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jabc_pkg::btn_cfg_t cfg_i,
  input  logic              fire_i,
  input  logic [31:0]       raw_i,
  output logic [31:0]       word_o
);
  import jabc_pkg::*;

  logic [31:0] last_raw_q, last_raw_d;
  logic [31:0] latched_q, latched_d;
  logic [31:0] phase_q, phase_d;
  logic [31:0] latched_word;
  logic        update;

  assign update = fire_i && cfg_i.enable;

  // Toggle latched buttons when any latched input changed, then autofire.
  always_comb begin
    latched_d = latched_q;
    if (((raw_i ^ last_raw_q) & cfg_i.latch_mask) != '0) begin
      latched_d = latched_q ^ (raw_i & cfg_i.latch_mask);
    end
    latched_word = (raw_i & ~cfg_i.latch_mask) | latched_d;
    phase_d      = (phase_q ^ cfg_i.autofire_mask) & latched_word;
    last_raw_d   = raw_i;
  end

  // Disabled: raw word passes unchanged.
  assign word_o = cfg_i.enable ? ((latched_word & ~cfg_i.autofire_mask) | phase_d) : raw_i;

  // Button state, touched only by an enabled button transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0;
      latched_q  <= '0;
      phase_q    <= '0;
    end else if (update) begin
      last_raw_q <= last_raw_d;
      latched_q  <= latched_d;
      phase_q    <= phase_d;
    end
  end

  `ASSERT_CLK(a_state_hold_raw, !update |=> $stable(last_raw_q), "press state moved without update")
  `ASSERT_CLK(a_state_hold_lat, !update |=> $stable(latched_q) && $stable(phase_q), "latch/phase moved without update")
  `ASSERT_CLK(a_latch_in_mask, update |=> ((latched_q ^ $past(latched_q)) & ~$past(cfg_i.latch_mask)) == '0, "latch bit toggled outside latch mask")

endmodule

// ===== rtl/joystick_axis_and_button_conditioner_core.sv =====
// Top level of the joystick axis and button conditioner.
// Depends on jabc_pkg, jabc_button_cond and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------
//  input    | in_valid_i / in_ready_o  | in_data_i  (in_t)
//  output   | out_valid_o / out_ready_i| out_data_o (out_t)
//  config   | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  One item per cycle sustained unless the output stalls; each result passes through
//  calibration table read, bound compare/subtract, gain multiply, shift/saturate.
//  Each stage holds on its own, so a waiting result stalls only the stages behind it.
//  Reset clears the active flags and button state; table bounds and gains are
//  undefined until written. Calibration writes give no result.

module joystick_axis_and_button_conditioner_core #(
  parameter int unsigned AXIS_COUNT = jabc_pkg::AXIS_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  jabc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jabc_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);
  import jabc_pkg::*;

  localparam int unsigned AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int unsigned PW = 33;
  localparam logic [6:0]  AxisCountW = 7'(AXIS_COUNT);

  // Configuration registers.
  logic        cal_en_q;
  logic [3:0]  axes_in_use_q;
  logic [31:0] latch_mask_q;
  logic [31:0] autofire_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_en_q        <= 1'b0;
      axes_in_use_q   <= AXES_IN_USE_RST;
      latch_mask_q    <= '0;
      autofire_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAL_ENABLE:  cal_en_q        <= cfg_data_i[0];
        REG_AXES_IN_USE: axes_in_use_q   <= cfg_data_i[3:0];
        REG_LATCH_MASK:  latch_mask_q    <= cfg_data_i;
        REG_AUTOFIRE:    autofire_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and stall chain.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic accept;

  assign out_free   = !out_v_q || out_ready_i;
  assign s3_free    = !s3_v_q || out_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && s1_free;

  // Input decode.
  logic [AW-1:0] addr;
  logic          in_range;
  logic          is_axis, is_button, is_cal;
  logic          axis_cal;

  assign addr     = AW'(in_data_i.axis_index);
  assign in_range = {4'b0, in_data_i.axis_index} < AxisCountW;

  always_comb begin
    is_axis   = 1'b0;
    is_button = 1'b0;
    is_cal    = 1'b0;
    unique case (in_data_i.kind)
      KIND_AXIS:   is_axis   = 1'b1;
      KIND_BUTTON: is_button = 1'b1;
      KIND_CAL:    is_cal    = 1'b1;
      default: ;
    endcase
  end

  // Active flags, cleared at reset.
  logic [AXIS_COUNT-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (accept && is_cal && in_range) begin
      active_q[addr] <= in_data_i.cal_active;
    end
  end

  assign axis_cal = cal_en_q && ({1'b0, in_data_i.axis_index} < axes_in_use_q)
                    && in_range && active_q[addr];

  // Calibration table: {high gain, low gain, high bound, low bound}.
  logic [63:0] cal_mem [AXIS_COUNT];
  logic [63:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && is_cal && in_range) begin
      cal_mem[addr] <= {in_data_i.cal_high_gain, in_data_i.cal_low_gain,
                        in_data_i.cal_high_dead, in_data_i.cal_low_dead};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      rd_q <= cal_mem[addr];
    end
  end

  // Button conditioning at transfer time.
  btn_cfg_t    btn_cfg;
  logic [31:0] btn_word;

  assign btn_cfg = '{enable: cal_en_q, latch_mask: latch_mask_q,
                     autofire_mask: autofire_mask_q};

  jabc_button_cond u_btn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (btn_cfg),
    .fire_i (accept && is_button),
    .raw_i  (in_data_i.button_word),
    .word_o (btn_word)
  );

  // Stage 1: item with its table entry.
  out_t s1_res_d, s1_res_q;
  logic s1_cal_q;

  always_comb begin
    s1_res_d = '0;
    if (is_button) begin
      s1_res_d.out_kind    = OUT_BUTTON;
      s1_res_d.out_buttons = btn_word;
    end else begin
      s1_res_d.out_kind       = OUT_AXIS;
      s1_res_d.out_axis_index = in_data_i.axis_index;
      s1_res_d.out_axis_value = in_data_i.axis_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= accept && (is_axis || is_button);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_res_q <= s1_res_d;
      s1_cal_q <= is_axis && axis_cal;
    end
  end

  // Stage 2: dead-zone compare and distance past the nearer bound.
  logic signed [15:0] x, lo, hi, glo, ghi;
  logic               below, above;
  logic signed [16:0] diff_d, diff_q;
  logic signed [15:0] gain_d, gain_q;
  out_t               s2_res_d, s2_res_q;
  logic               s2_scale_q;

  always_comb begin
    x        = s1_res_q.out_axis_value;
    lo       = rd_q[15:0];
    hi       = rd_q[31:16];
    glo      = rd_q[47:32];
    ghi      = rd_q[63:48];
    below    = x < lo;
    above    = x > hi;
    diff_d   = below ? (17'(x) - 17'(lo)) : (17'(x) - 17'(hi));
    gain_d   = below ? glo : ghi;
    s2_res_d = s1_res_q;
    if (s1_cal_q && !below && !above) begin
      s2_res_d.out_axis_value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_res_q   <= s2_res_d;
      s2_scale_q <= s1_cal_q && (below || above);
      diff_q     <= diff_d;
      gain_q     <= gain_d;
    end
  end

  // Stage 3: gain multiply at full width.
  logic signed [PW-1:0] prod_d, prod_q;
  out_t                 s3_res_q;
  logic                 s3_scale_q;

  assign prod_d = PW'(diff_q) * PW'(gain_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free) begin
      s3_res_q   <= s2_res_q;
      s3_scale_q <= s2_scale_q;
      prod_q     <= prod_d;
    end
  end

  // Output stage: floor shift and saturate.
  logic signed [PW-1:0] scaled;
  out_t                 out_res_d, out_res_q;

  always_comb begin
    scaled    = prod_q >>> GAIN_SHIFT;
    out_res_d = s3_res_q;
    if (s3_scale_q) begin
      if (scaled > PW'(AXIS_MAX)) begin
        out_res_d.out_axis_value = AXIS_MAX;
      end else if (scaled < PW'(AXIS_MIN)) begin
        out_res_d.out_axis_value = AXIS_MIN;
      end else begin
        out_res_d.out_axis_value = scaled[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_res_q;

  `ASSERT_CLK(a_btn_fields, out_v_q && (out_res_q.out_kind == OUT_BUTTON) |-> out_res_q.out_axis_index == '0 && out_res_q.out_axis_value == '0, "button result carries axis fields")
  `ASSERT_CLK(a_axis_fields, out_v_q && (out_res_q.out_kind == OUT_AXIS) |-> out_res_q.out_buttons == '0, "axis result carries button bits")
  `ASSERT_CLK(a_scale_axis, s3_v_q && s3_scale_q |-> s3_res_q.out_kind == OUT_AXIS, "scaling flagged on a button item")
  `ASSERT_CLK(a_cal_no_result, accept && is_cal |=> !s1_v_q, "calibration write produced a result")

endmodule
